[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the tuning word sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset.
`define DTW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that cond never holds outside reset.
`define DTW_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[src/dtw_pkg.sv]
// ----------------------------------------------------------------------------
// dtw_pkg
// Types, widths and command codes of the DDS tuning word sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dtw_pkg;

    localparam int FREQ_W  = 27;
    localparam int SCALE_W = 29;
    localparam int PHASE_W = 12;
    localparam int WORD_W  = 16;
    localparam int PROD_W  = FREQ_W + SCALE_W;
    localparam int REM_W   = 24;
    localparam int QBITS   = PROD_W - (REM_W - 1);
    localparam int TW_W    = 28;
    localparam int HALF_W  = TW_W / 2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 29'd10737418;
    // 10^6 Hz per MHz times ten tenths per hertz; above 2^23, below 2^24
    localparam logic [REM_W-1:0]   DIVISOR     = 24'd10000000;

    localparam logic [WORD_W-1:0] CMD_RESET     = 16'h0100;
    localparam logic [WORD_W-1:0] CMD_B28_RESET = 16'h2100;
    localparam logic [WORD_W-1:0] TAG_REG0      = 16'h4000;
    localparam logic [WORD_W-1:0] TAG_REG1      = 16'h8000;
    localparam logic [WORD_W-1:0] PHASE_PREFIX  = 16'hC000;
    localparam logic [WORD_W-1:0] CTRL_SINE     = 16'h2000;
    localparam logic [WORD_W-1:0] CTRL_TRIANGLE = 16'h2002;
    localparam logic [WORD_W-1:0] CTRL_SQUARE   = 16'h2028;

    typedef enum logic [1:0] {
        MODE_SINE     = 2'd0,
        MODE_TRIANGLE = 2'd1,
        MODE_SQUARE   = 2'd2,
        MODE_NONE     = 2'd3
    } wave_mode_t;

    typedef enum logic [2:0] {
        W_RESET = 3'd0,
        W_B28   = 3'd1,
        W_LO    = 3'd2,
        W_HI    = 3'd3,
        W_PHASE = 3'd4,
        W_CTRL  = 3'd5
    } word_idx_t;

    // Request fields that ride along the arithmetic pipeline
    typedef struct packed {
        logic               reg_select;
        logic [1:0]         wave_mode;
        logic [PHASE_W-1:0] phase;
    } side_t;

    function automatic logic [WORD_W-1:0] ctrl_word(input logic [1:0] mode);
        logic [WORD_W-1:0] w;
        case (mode)
            MODE_SINE:     w = CTRL_SINE;
            MODE_TRIANGLE: w = CTRL_TRIANGLE;
            MODE_SQUARE:   w = CTRL_SQUARE;
            default:       w = CTRL_SINE;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[src/dtw_req_if.sv]
// ----------------------------------------------------------------------------
// dtw_req_if
// Waveform request channel: valid/ready with the request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtw_req_if;
    logic                        valid;
    logic                        ready;
    logic [dtw_pkg::FREQ_W-1:0]  freq_decihz;
    logic                        reg_select;
    logic [1:0]                  wave_mode;
    logic [dtw_pkg::PHASE_W-1:0] phase;

    modport source (output valid, freq_decihz, reg_select, wave_mode, phase, input ready);
    modport sink   (input valid, freq_decihz, reg_select, wave_mode, phase, output ready);
endinterface

`default_nettype wire

[src/dtw_cmd_if.sv]
// ----------------------------------------------------------------------------
// dtw_cmd_if
// Command word channel: valid/ready with one 16-bit word and its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtw_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [dtw_pkg::WORD_W-1:0] spi_word;
    logic                       last;

    modport source (output valid, spi_word, last, input ready);
    modport sink   (input valid, spi_word, last, output ready);
endinterface

`default_nettype wire

[src/dtw_mult.sv]
// ----------------------------------------------------------------------------
// dtw_mult
// First pipeline stage: frequency times tuning scale, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dtw_mult (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         adv,
    input  wire logic                         in_valid,
    input  wire logic [dtw_pkg::FREQ_W-1:0]   freq,
    input  wire logic [dtw_pkg::SCALE_W-1:0]  scale,
    input  wire dtw_pkg::side_t               side_in,
    output logic                              out_valid,
    output logic [dtw_pkg::PROD_W-1:0]        prod,
    output dtw_pkg::side_t                    side_out
);
    import dtw_pkg::*;

    logic              valid_reg;
    logic [PROD_W-1:0] prod_reg;
    side_t             side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= PROD_W'(freq) * PROD_W'(scale);
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign prod      = prod_reg;
    assign side_out  = side_reg;

endmodule

`default_nettype wire

[src/dtw_div.sv]
// ----------------------------------------------------------------------------
// dtw_div
// Pipelined restoring division of the product by 10^7, three quotient bits
// per stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dtw_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        adv,
    input  wire logic                        in_valid,
    input  wire logic [dtw_pkg::PROD_W-1:0]  prod,
    input  wire dtw_pkg::side_t              side_in,
    output logic                             out_valid,
    output logic [dtw_pkg::TW_W-1:0]         tw,
    output dtw_pkg::side_t                   side_out
);
    import dtw_pkg::*;

    localparam int STEPS   = 3;
    localparam int NSTAGES = QBITS / STEPS;

    logic             v_reg    [NSTAGES];
    logic [REM_W-1:0] rem_reg  [NSTAGES];
    logic [QBITS-1:0] lo_reg   [NSTAGES];
    side_t            side_reg [NSTAGES];

    logic             v_in     [NSTAGES];
    logic [REM_W-1:0] rem_in   [NSTAGES];
    logic [QBITS-1:0] lo_in    [NSTAGES];
    side_t            side_pin [NSTAGES];
    logic [REM_W-1:0] rem_next [NSTAGES];
    logic [QBITS-1:0] lo_next  [NSTAGES];

    for (genvar k = 0; k < NSTAGES; k++)
    begin : g_stage
        if (k == 0)
        begin : g_first
            // top bits stay below the divisor, so they seed the remainder
            assign v_in[k]     = in_valid;
            assign rem_in[k]   = {1'b0, prod[PROD_W-1:QBITS]};
            assign lo_in[k]    = prod[QBITS-1:0];
            assign side_pin[k] = side_in;
        end
        else
        begin : g_rest
            assign v_in[k]     = v_reg[k-1];
            assign rem_in[k]   = rem_reg[k-1];
            assign lo_in[k]    = lo_reg[k-1];
            assign side_pin[k] = side_reg[k-1];
        end

        // shift one dividend bit into the remainder, subtract when it fits,
        // shift the quotient bit in at the bottom
        always_comb
        begin : p_step
            logic [REM_W-1:0] r;
            logic [QBITS-1:0] l;
            logic [REM_W:0]   t;
            r = rem_in[k];
            l = lo_in[k];
            for (int s = 0; s < STEPS; s++)
            begin
                t = {r, l[QBITS-1]};
                l = {l[QBITS-2:0], 1'b0};
                if (t >= {1'b0, DIVISOR})
                begin
                    r    = REM_W'(t - {1'b0, DIVISOR});
                    l[0] = 1'b1;
                end
                else
                begin
                    r = t[REM_W-1:0];
                end
            end
            rem_next[k] = r;
            lo_next[k]  = l;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= v_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next[k];
                lo_reg[k]   <= lo_next[k];
                side_reg[k] <= side_pin[k];
            end
        end
    end

    // only the low 28 quotient bits go to the synthesizer
    assign out_valid = v_reg[NSTAGES-1];
    assign tw        = lo_reg[NSTAGES-1][TW_W-1:0];
    assign side_out  = side_reg[NSTAGES-1];

    `DTW_ASSERT(a_rem_first_below_div, clk, rst_n, v_reg[0] |-> (rem_reg[0] < DIVISOR), "remainder out of range after first divide stage")
    `DTW_ASSERT(a_rem_last_below_div, clk, rst_n, v_reg[NSTAGES-1] |-> (rem_reg[NSTAGES-1] < DIVISOR), "remainder out of range after last divide stage")

endmodule

`default_nettype wire

[src/dtw_seq.sv]
// ----------------------------------------------------------------------------
// dtw_seq
// Word sequencer: holds one tuning result and emits its command words.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dtw_seq (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic [dtw_pkg::TW_W-1:0]  tw,
    input  wire dtw_pkg::side_t            side_in,
    output logic                           take,
    dtw_cmd_if.source                      cmd
);
    import dtw_pkg::*;

    logic              busy_reg, busy_next;
    word_idx_t         idx_reg, idx_next;
    logic [TW_W-1:0]   tw_reg;
    side_t             side_reg;
    logic [WORD_W-1:0] tag;
    logic [WORD_W-1:0] word;
    logic              final_word;
    logic              fire;

    assign tag        = side_reg.reg_select ? TAG_REG1 : TAG_REG0;
    assign final_word = (idx_reg == W_CTRL) ||
                        ((idx_reg == W_PHASE) && (side_reg.wave_mode == MODE_NONE));
    assign fire       = busy_reg && cmd.ready;
    // load the next result while idle or as the current one hands over its last word
    assign take       = in_valid && (!busy_reg || (fire && final_word));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= W_RESET;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tw_reg   <= tw;
            side_reg <= side_in;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (take)
        begin
            busy_next = 1'b1;
            idx_next  = W_RESET;
        end
        else if (fire)
        begin
            if (final_word)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = word_idx_t'(3'(idx_reg + 3'd1));
            end
        end
    end

    always_comb
    begin
        case (idx_reg)
            W_RESET: word = CMD_RESET;
            W_B28:   word = CMD_B28_RESET;
            W_LO:    word = tag | WORD_W'(tw_reg[HALF_W-1:0]);
            W_HI:    word = tag | WORD_W'(tw_reg[TW_W-1:HALF_W]);
            W_PHASE: word = PHASE_PREFIX | WORD_W'(side_reg.phase);
            W_CTRL:  word = ctrl_word(side_reg.wave_mode);
            default: word = CMD_RESET;
        endcase
    end

    assign cmd.valid    = busy_reg;
    assign cmd.spi_word = word;
    assign cmd.last     = final_word;

    `DTW_ASSERT(a_last_on_tail, clk, rst_n, (cmd.valid && cmd.last) |-> ((idx_reg == W_CTRL) || (idx_reg == W_PHASE)), "last flag on a word that cannot end a request")
    `DTW_ASSERT(a_no_gap_in_request, clk, rst_n, (fire && !final_word) |=> (cmd.valid && !$stable(idx_reg)), "request words did not continue after a taken word")

endmodule

`default_nettype wire

[src/dds_tuning_word_command_sequencer_core.sv]
// ----------------------------------------------------------------------------
// dds_tuning_word_command_sequencer_core
// Turns waveform requests into the command words of a 28-bit DDS.
// ----------------------------------------------------------------------------
// Each request gives 0x0100, 0x2100, the low and high 14 tuning word bits
// with the register tag, the phase word and the wave control word (five
// words when wave_mode is 3). The tuning word is the low 28 bits of the
// exact floor(freq * scale / 10^7), computed in a 12-stage pipeline: one
// multiply stage followed by eleven divide stages that each produce three
// quotient bits. The sequencer registers a result of the last divide stage,
// then emits one word per cycle while the receiver is ready, and takes the
// next result when idle or as the current one hands over its last word,
// while up to twelve more requests wait in the pipeline. cfg_wdata written
// with cfg_we replaces the tuning scale; write it while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_tuning_word_command_sequencer_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [dtw_pkg::SCALE_W-1:0]  cfg_wdata,
    dtw_req_if.sink                           req,
    dtw_cmd_if.source                         cmd
);
    import dtw_pkg::*;

    logic [SCALE_W-1:0] scale_reg;
    logic               adv;
    logic               take;
    side_t              req_side;

    logic               mul_valid;
    logic [PROD_W-1:0]  mul_prod;
    side_t              mul_side;

    logic               div_valid;
    logic [TW_W-1:0]    div_tw;
    side_t              div_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            scale_reg <= cfg_wdata;
        end
    end

    // advance the whole pipe unless its tail holds a result the sequencer
    // cannot take yet
    assign adv       = !div_valid || take;
    assign req.ready = adv;

    assign req_side.reg_select = req.reg_select;
    assign req_side.wave_mode  = req.wave_mode;
    assign req_side.phase      = req.phase;

    dtw_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (req.valid),
        .freq      (req.freq_decihz),
        .scale     (scale_reg),
        .side_in   (req_side),
        .out_valid (mul_valid),
        .prod      (mul_prod),
        .side_out  (mul_side)
    );

    dtw_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (mul_valid),
        .prod      (mul_prod),
        .side_in   (mul_side),
        .out_valid (div_valid),
        .tw        (div_tw),
        .side_out  (div_side)
    );

    dtw_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_valid),
        .tw       (div_tw),
        .side_in  (div_side),
        .take     (take),
        .cmd      (cmd)
    );

endmodule

`default_nettype wire

[sim/dds_tuning_word_command_sequencer_core_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_tuning_word_command_sequencer_core_checker
// Watches the request and command channels, works out the command words that
// each accepted request must give under the current tuning scale, and
// compares every word that leaves the block with the oldest one still due.
// ----------------------------------------------------------------------------

module dds_tuning_word_command_sequencer_core_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [dtw_pkg::SCALE_W-1:0]  cfg_wdata,
    dtw_req_if                           req,
    dtw_cmd_if                           cmd,
    output int                           fail_count,
    output int                           words_pending
);
    import dtw_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] spi_word;
        logic              last;
    } cmd_word_t;

    cmd_word_t          words_due[$];
    logic [SCALE_W-1:0] scale;
    int                 failures;

    assign fail_count = failures;

    task automatic queue_request_words(
        input logic [FREQ_W-1:0]  freq,
        input logic               sel,
        input wave_mode_t         mode,
        input logic [PHASE_W-1:0] ph
    );
        logic [63:0]       tw;
        logic [WORD_W-1:0] tag;
        logic [WORD_W-1:0] ctrl;
        // exact floor division; bits above 27 fall away below
        tw = ({37'd0, freq} * {35'd0, scale}) / {40'd0, DIVISOR};
        tag = sel ? TAG_REG1 : TAG_REG0;
        words_due.push_back('{CMD_RESET, 1'b0});
        words_due.push_back('{CMD_B28_RESET, 1'b0});
        words_due.push_back('{tag | {2'b00, tw[13:0]}, 1'b0});
        words_due.push_back('{tag | {2'b00, tw[27:14]}, 1'b0});
        words_due.push_back('{PHASE_PREFIX | {4'h0, ph}, mode == MODE_NONE});
        if (mode != MODE_NONE)
        begin
            case (mode)
                MODE_SINE:     ctrl = CTRL_SINE;
                MODE_TRIANGLE: ctrl = CTRL_TRIANGLE;
                default:       ctrl = CTRL_SQUARE;
            endcase
            words_due.push_back('{ctrl, 1'b1});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cmd_word_t want;
        if (!rst_n)
        begin
            scale <= SCALE_RESET;
            words_due.delete();
            failures = 0;
            words_pending <= 0;
        end
        else
        begin
            if (cfg_we)
                scale <= cfg_wdata;
            if (req.valid && req.ready)
                queue_request_words(req.freq_decihz, req.reg_select,
                                    wave_mode_t'(req.wave_mode), req.phase);
            if (cmd.valid && cmd.ready)
            begin
                if (words_due.size() == 0)
                begin
                    $error("command word %h (last %b) with no word due",
                           cmd.spi_word, cmd.last);
                    failures++;
                end
                else
                begin
                    want = words_due.pop_front();
                    if (cmd.spi_word !== want.spi_word)
                    begin
                        $error("spi_word: expected %h, actual %h", want.spi_word,
                               cmd.spi_word);
                        failures++;
                    end
                    if (cmd.last !== want.last)
                    begin
                        $error("last: expected %b, actual %b", want.last, cmd.last);
                        failures++;
                    end
                end
            end
            words_pending <= words_due.size();
        end
    end

endmodule

[sim/dds_tuning_word_command_sequencer_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_tuning_word_command_sequencer_core_test
// Drives waveform requests into the sequencer under several tuning scales,
// first the edge cases, then random requests under three idling profiles,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------

module dds_tuning_word_command_sequencer_core_test;
    import dtw_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE1_ITEMS   = 140;
    localparam int PHASE2_ITEMS   = 140;
    localparam int PHASE3_ITEMS   = 150;

    localparam logic [SCALE_W-1:0] SCALE_TOP  = 29'd268435456;
    localparam logic [SCALE_W-1:0] SCALE_FULL = '1;
    localparam logic [FREQ_W-1:0]  FREQ_TOP   = 27'd120000000;
    localparam logic [FREQ_W-1:0]  FREQ_FULL  = '1;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [SCALE_W-1:0] cfg_wdata;
    int                 fail_count;
    int                 words_pending;
    int                 src_idle_pct;
    int                 sink_idle_pct;
    int                 hold_request;
    int                 hold_left;
    int                 quiet_cycles;

    dtw_req_if req_ch();
    dtw_cmd_if cmd_ch();

    dds_tuning_word_command_sequencer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .cmd       (cmd_ch)
    );

    dds_tuning_word_command_sequencer_core_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .req           (req_ch),
        .cmd           (cmd_ch),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Receiver: random stalls, plus a long hold-off when one is requested
    initial
    begin
        hold_left = 0;
        cmd_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                cmd_ch.ready <= 1'b0;
            end
            else
                cmd_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (cmd_ch.valid && cmd_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[dds_tuning_word_command_sequencer_core] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Keep valid high across back-to-back requests; drop it only for a gap
    task automatic offer_request(
        input logic [FREQ_W-1:0]  freq,
        input logic               sel,
        input wave_mode_t         mode,
        input logic [PHASE_W-1:0] ph
    );
        if ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        req_ch.valid       <= 1'b1;
        req_ch.freq_decihz <= freq;
        req_ch.reg_select  <= sel;
        req_ch.wave_mode   <= mode;
        req_ch.phase       <= ph;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
    endtask

    task automatic offer_random_request();
        logic [FREQ_W-1:0] f;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 5)
            f = '0;
        else if (pick < 10)
            f = FREQ_TOP;
        else if (pick < 15)
            f = FREQ_FULL;
        else if (pick < 30)
            f = FREQ_W'($urandom);
        else if (pick < 45)
            f = FREQ_W'($urandom_range(10000));
        else
            f = FREQ_W'($urandom_range(FREQ_TOP));
        offer_request(f, 1'($urandom), wave_mode_t'($urandom_range(3)), PHASE_W'($urandom));
    endtask

    // Stop offering and hold until every word due has left the block
    task automatic drain(input int settle);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] value);
        drain(DRAIN_CYCLES);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.freq_decihz <= '0;
        req_ch.reg_select  <= 1'b0;
        req_ch.wave_mode   <= MODE_SINE;
        req_ch.phase       <= '0;
        hold_request       = 0;
        src_idle_pct       = 14;
        sink_idle_pct      = 80;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset scale: field extremes, every mode, both register tags
        offer_request('0, 1'b0, MODE_SINE, 12'h000);
        offer_request(FREQ_TOP, 1'b1, MODE_TRIANGLE, 12'hFFF);
        offer_request(FREQ_FULL, 1'b0, MODE_SQUARE, 12'hAAA);
        offer_request(27'd1, 1'b1, MODE_NONE, 12'h555);
        offer_request(27'd10, 1'b0, MODE_NONE, 12'hFFF);
        offer_request(27'd10000000, 1'b1, MODE_SINE, 12'h000);
        offer_request(27'h2AAAAAA, 1'b0, MODE_TRIANGLE, 12'hFFF);
        offer_request(27'h5555555, 1'b1, MODE_SQUARE, 12'h001);

        // Full-width scale: tuning word wider than 28 bits wraps
        write_scale(SCALE_FULL);
        offer_request(FREQ_FULL, 1'b1, MODE_SINE, 12'h123);
        offer_request(FREQ_TOP, 1'b0, MODE_NONE, 12'hFFF);
        offer_request(27'd12345678, 1'b1, MODE_TRIANGLE, 12'h800);

        // Zero scale gives a zero tuning word
        write_scale('0);
        offer_request(FREQ_TOP, 1'b0, MODE_SQUARE, 12'h7FF);
        offer_request(FREQ_FULL, 1'b1, MODE_NONE, 12'h000);

        // Unit scale: floor just below and at the divisor
        write_scale(29'd1);
        offer_request(FREQ_FULL, 1'b0, MODE_SINE, 12'hFFF);
        offer_request(27'd9999999, 1'b1, MODE_TRIANGLE, 12'h001);
        offer_request(27'd10000000, 1'b0, MODE_SQUARE, 12'hFFE);

        write_scale(SCALE_TOP);
        offer_request(FREQ_TOP, 1'b1, MODE_SQUARE, 12'h3C3);
        offer_request(27'd1, 1'b0, MODE_NONE, 12'hC3C);

        // Sender mostly busy, receiver mostly stalled; one long hold-off
        write_scale(SCALE_W'($urandom_range(SCALE_TOP, 1)));
        for (int i = 0; i < PHASE1_ITEMS; i++)
        begin
            if (i == 40)
                hold_request = LONG_HOLD;
            offer_random_request();
        end

        src_idle_pct  = 80;
        sink_idle_pct = 14;
        write_scale(SCALE_RESET);
        for (int i = 0; i < PHASE2_ITEMS; i++)
        begin
            if (i == PHASE2_ITEMS / 2)
                drain(0);
            offer_random_request();
        end

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_scale(SCALE_W'($urandom));
        for (int i = 0; i < PHASE3_ITEMS; i++)
            offer_random_request();

        drain(DRAIN_CYCLES);
        if (fail_count == 0)
            $display("[dds_tuning_word_command_sequencer_core] OK");
        else
            $display("[dds_tuning_word_command_sequencer_core] ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/dtw_pkg.sv
src/dtw_req_if.sv
src/dtw_cmd_if.sv
src/dtw_mult.sv
src/dtw_div.sv
src/dtw_seq.sv
src/dds_tuning_word_command_sequencer_core.sv
sim/dds_tuning_word_command_sequencer_core_checker.sv
sim/dds_tuning_word_command_sequencer_core_test.sv
